### sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define OWB_ASSERT_IMPLY(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("owb check failed");

// Next-cycle implication, checked out of reset
`define OWB_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("owb check failed");

`endif

### sv/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg
// Types and constants shared by the 1-Wire bus master front, back and top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package owb_pkg;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Field widths
    localparam int RST_W      = 10;
    localparam int US_W       = 8;
    localparam int BYTE_W     = 8;
    localparam int BIT_IDX_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT        = 3'd5;

    // Register reset values
    localparam logic [RST_W-1:0] RST_RESET_LOW   = 10'd480;
    localparam logic [US_W-1:0]  RST_PRESENCE    = 8'd150;
    localparam logic [US_W-1:0]  RST_SHORT_LOW   = 8'd6;
    localparam logic [US_W-1:0]  RST_LONG_LOW    = 8'd60;
    localparam logic [US_W-1:0]  RST_READ_SAMPLE = 8'd9;
    localparam logic [US_W-1:0]  RST_SLOT        = 8'd70;

    // Command codes
    typedef enum logic [1:0] {
        FUNC_RESET = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // Classified request as held in the queue
    typedef struct packed {
        logic              tick;
        logic              level;
        logic              start;   // start request with a valid command
        t_func             func;
        logic [BYTE_W-1:0] tx;
    } t_item;

    // Timing registers
    typedef struct packed {
        logic [RST_W-1:0] reset_low;
        logic [US_W-1:0]  presence;
        logic [US_W-1:0]  short_low;
        logic [US_W-1:0]  long_low;
        logic [US_W-1:0]  read_sample;
        logic [US_W-1:0]  slot;
    } t_cfg;

    // One result
    typedef struct packed {
        logic              drive_low;
        logic              busy;
        logic              done;
        logic              present;
        logic [BYTE_W-1:0] rx_byte;
    } t_result;

endpackage

`default_nettype wire

### sv/owb_front.sv
// ----------------------------------------------------------------------------
// owb_front
// Accepts requests, classifies the command and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module owb_front #(
    parameter int DEPTH = owb_pkg::QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output      logic                       o_in_ready,
    input  wire logic                       i_tick,
    input  wire logic                       i_line_level,
    input  wire logic                       i_start_req,
    input  wire logic [1:0]                 i_func,
    input  wire logic [owb_pkg::BYTE_W-1:0] i_tx_byte,
    output      owb_pkg::t_item             o_item,
    output      logic                       o_item_valid,
    input  wire logic                       i_item_pop
);
    import owb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    t_item            w_item;
    logic             w_push;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Classification: func 3 never starts a command
    always_comb begin
        w_item.tick  = i_tick;
        w_item.level = i_line_level;
        w_item.start = i_start_req && (i_func != FUNC_NONE);
        w_item.func  = t_func'(i_func);
        w_item.tx    = i_tx_byte;
    end

    assign o_in_ready   = (r_count != CNT_W'(DEPTH));
    assign w_push       = i_in_valid && o_in_ready;
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];

    // Pointer and fill tracking
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = ptr_inc(r_wr_ptr);
        end
        if (i_item_pop) begin
            n_rd_ptr = ptr_inc(r_rd_ptr);
        end
        if (w_push && !i_item_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_item_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

### sv/owb_back.sv
// ----------------------------------------------------------------------------
// owb_back
// Bus timing sequencer: one queued request per cycle, result in an output
// register; the queue is popped while that register is empty or being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module owb_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire owb_pkg::t_item   i_item,
    input  wire logic             i_item_valid,
    output      logic             o_item_pop,
    input  wire owb_pkg::t_cfg    i_cfg,
    output      owb_pkg::t_result o_res,
    output      logic             o_out_valid,
    input  wire logic             i_out_ready
);
    import owb_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_RST_LOW  = 4'b0010,
        PH_RST_WAIT = 4'b0100,
        PH_SLOT     = 4'b1000
    } t_phase;

    t_phase               r_phase,   n_phase;
    t_func                r_op,      n_op;
    logic [RST_W-1:0]     r_time,    n_time;
    logic [BIT_IDX_W-1:0] r_bit,     n_bit;
    logic [BYTE_W-1:0]    r_shift,   n_shift;
    logic [BYTE_W-1:0]    r_rx,      n_rx;
    logic                 r_present, n_present;
    logic                 r_out_valid, n_out_valid;
    t_result              r_res,     n_res;

    logic [US_W-1:0]      w_low_old, w_low_new, w_slot_len, w_samp;
    logic [US_W:0]        w_sum;
    logic [RST_W-1:0]     w_time_inc;
    logic [BYTE_W-1:0]    w_sr;
    logic                 w_done, w_drive;

    assign o_item_pop  = i_item_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    // Slot timing from the current bit
    always_comb begin
        w_low_old  = (r_op == FUNC_WRITE && !r_shift[0]) ? i_cfg.long_low : i_cfg.short_low;
        w_slot_len = (w_low_old > i_cfg.slot) ? w_low_old : i_cfg.slot;
        if (w_slot_len == '0) begin
            w_slot_len = US_W'(1);
        end
        w_sum  = {1'b0, i_cfg.short_low} + {1'b0, i_cfg.read_sample};
        w_samp = (w_sum > {1'b0, w_slot_len}) ? w_slot_len : w_sum[US_W-1:0];
        if (w_samp == '0) begin
            w_samp = US_W'(1);
        end
        w_time_inc = r_time + 1'b1;
    end

    // Sequencer step
    always_comb begin
        n_phase   = r_phase;
        n_op      = r_op;
        n_time    = r_time;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_rx      = r_rx;
        n_present = r_present;
        w_sr      = r_shift;
        w_done    = 1'b0;
        if (o_item_pop) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_item.start) begin
                        n_op    = i_item.func;
                        n_time  = '0;
                        n_bit   = '0;
                        n_shift = i_item.tx;
                        n_phase = (i_item.func == FUNC_RESET) ? PH_RST_LOW : PH_SLOT;
                    end
                end
                PH_RST_LOW: begin
                    if (i_item.tick) begin
                        n_time = w_time_inc;
                        if (w_time_inc >= i_cfg.reset_low) begin
                            n_phase = PH_RST_WAIT;
                            n_time  = '0;
                        end
                    end
                end
                PH_RST_WAIT: begin
                    if (i_item.tick) begin
                        n_time = w_time_inc;
                        if (w_time_inc >= RST_W'(i_cfg.presence)) begin
                            n_present = !i_item.level;
                            n_phase   = PH_IDLE;
                            n_time    = '0;
                            w_done    = 1'b1;
                        end
                    end
                end
                PH_SLOT: begin
                    if (i_item.tick) begin
                        n_time = w_time_inc;
                        // read sample comes before end of slot
                        if (r_op == FUNC_READ && w_time_inc == RST_W'(w_samp)) begin
                            w_sr = {i_item.level, r_shift[BYTE_W-1:1]};
                        end
                        if (w_time_inc >= RST_W'(w_slot_len)) begin
                            if (r_op != FUNC_READ) begin
                                w_sr = r_shift >> 1;
                            end
                            n_time = '0;
                            if (r_bit == BIT_IDX_W'(BYTE_W - 1)) begin
                                if (r_op == FUNC_READ) begin
                                    n_rx = w_sr;
                                end
                                n_bit   = '0;
                                n_phase = PH_IDLE;
                                w_done  = 1'b1;
                            end else begin
                                n_bit = r_bit + 1'b1;
                            end
                        end
                        n_shift = w_sr;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Line drive from the state after the step
    always_comb begin
        w_low_new = (n_op == FUNC_WRITE && !n_shift[0]) ? i_cfg.long_low : i_cfg.short_low;
        w_drive   = (n_phase == PH_RST_LOW) ||
                    (n_phase == PH_SLOT && n_time < RST_W'(w_low_new));
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_res       = r_res;
        if (o_item_pop) begin
            n_out_valid     = 1'b1;
            n_res.drive_low = w_drive;
            n_res.busy      = (n_phase != PH_IDLE);
            n_res.done      = w_done;
            n_res.present   = n_present;
            n_res.rx_byte   = n_rx;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_op        <= FUNC_RESET;
            r_time      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_rx        <= '0;
            r_present   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_op        <= n_op;
            r_time      <= n_time;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_rx        <= n_rx;
            r_present   <= n_present;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

`default_nettype wire

### sv/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master timed by microsecond ticks: reset with presence detect,
// byte write and byte read, least significant bit first.
// ----------------------------------------------------------------------------
// Each request carries one time step (tick, sampled line level, optional
// command) and yields exactly one result with the line drive, busy, done,
// presence and last read byte after that step. One request is taken every
// clock cycle while the queue has room; its result passes through the
// queue and then the result register before it can be taken. The step of
// the timing sequencer sets the rate; a two-entry queue sits between the
// request classifier and the sequencer, and the result register lets the
// queue keep filling while a result waits. The user must write the timing
// registers through the plain write port only while no command is running
// (the block does not enforce this); they reset to 480/150/6/60/9/70 us.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module one_wire_bus_master #(
    parameter int QUEUE_DEPTH = owb_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic                           i_tick,
    input  wire logic                           i_line_level,
    input  wire logic                           i_start_req,
    input  wire logic [1:0]                     i_func,
    input  wire logic [owb_pkg::BYTE_W-1:0]     i_tx_byte,
    // result channel
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic                           o_drive_low,
    output      logic                           o_busy_res,
    output      logic                           o_done_res,
    output      logic                           o_device_present,
    output      logic [owb_pkg::BYTE_W-1:0]     o_rx_byte,
    // register write port
    input  wire logic                           i_cfg_we,
    input  wire logic [owb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [owb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import owb_pkg::*;

    t_cfg    r_cfg, n_cfg;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_item_pop;
    t_result w_res;

    // Timing registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RESET_LOW:   n_cfg.reset_low   = i_cfg_data[RST_W-1:0];
                REG_PRESENCE:    n_cfg.presence    = i_cfg_data[US_W-1:0];
                REG_SHORT_LOW:   n_cfg.short_low   = i_cfg_data[US_W-1:0];
                REG_LONG_LOW:    n_cfg.long_low    = i_cfg_data[US_W-1:0];
                REG_READ_SAMPLE: n_cfg.read_sample = i_cfg_data[US_W-1:0];
                REG_SLOT:        n_cfg.slot        = i_cfg_data[US_W-1:0];
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low   <= RST_RESET_LOW;
            r_cfg.presence    <= RST_PRESENCE;
            r_cfg.short_low   <= RST_SHORT_LOW;
            r_cfg.long_low    <= RST_LONG_LOW;
            r_cfg.read_sample <= RST_READ_SAMPLE;
            r_cfg.slot        <= RST_SLOT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front: classify and queue
    owb_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_tick       (i_tick),
        .i_line_level (i_line_level),
        .i_start_req  (i_start_req),
        .i_func       (i_func),
        .i_tx_byte    (i_tx_byte),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop)
    );

    // Back: bus timing sequencer
    owb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .i_cfg        (r_cfg),
        .o_res        (w_res),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready)
    );

    assign o_drive_low      = w_res.drive_low;
    assign o_busy_res       = w_res.busy;
    assign o_done_res       = w_res.done;
    assign o_device_present = w_res.present;
    assign o_rx_byte        = w_res.rx_byte;

    // Checks
    `OWB_ASSERT_NEXT(a_push_fills_queue, i_clk, i_rst_n, i_in_valid && o_in_ready, w_item_valid)
    `OWB_ASSERT_IMPLY(a_done_not_busy, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res)
    `OWB_ASSERT_IMPLY(a_drive_when_busy, i_clk, i_rst_n, o_out_valid && o_drive_low, o_busy_res)
    `OWB_ASSERT_IMPLY(a_rx_only_on_done, i_clk, i_rst_n,
        o_out_valid && !o_done_res && $past(o_out_valid && i_out_ready),
        o_rx_byte == $past(o_rx_byte))

endmodule

`default_nettype wire

### tb/owb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_checker
// Watches the request, result and register ports of the 1-Wire bus master,
// predicts the bus status after every timing step and compares each result.
// ----------------------------------------------------------------------------

module owb_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic                           i_tick,
    input  wire logic                           i_line_level,
    input  wire logic                           i_start_req,
    input  wire logic [1:0]                     i_func,
    input  wire logic [owb_pkg::BYTE_W-1:0]     i_tx_byte,
    // result channel
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic                           i_drive_low,
    input  wire logic                           i_busy_res,
    input  wire logic                           i_done_res,
    input  wire logic                           i_device_present,
    input  wire logic [owb_pkg::BYTE_W-1:0]     i_rx_byte,
    // register write port
    input  wire logic                           i_cfg_we,
    input  wire logic [owb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [owb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // summary for the top
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_finished,
    output logic                                o_busy
);
    import owb_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_SLOT
    } t_bus_phase;

    // Own copy of the timing registers and sequencer state
    t_cfg              timing;
    t_bus_phase        bus_ph;
    t_func             op_kind;
    logic [RST_W-1:0]  tcount;
    logic [2:0]        bit_idx;
    logic [BYTE_W-1:0] shreg;
    logic [BYTE_W-1:0] rd_byte;
    logic              present;

    // Predicted bus status, oldest first
    t_result           bus_status_q[$];

    // Low pulse of the current slot: long only for a written zero
    function automatic logic [US_W-1:0] pulse_len();
        if (op_kind == FUNC_WRITE && !shreg[0])
            return timing.long_low;
        return timing.short_low;
    endfunction

    // A pulse longer than the slot stretches it; never shorter than one tick
    function automatic logic [US_W-1:0] slot_len();
        logic [US_W-1:0] n;
        n = timing.slot;
        if (pulse_len() > n)
            n = pulse_len();
        if (n == '0)
            n = US_W'(1);
        return n;
    endfunction

    // Read sample point, clipped to the slot and at least one tick
    function automatic logic [US_W-1:0] sample_at();
        logic [US_W:0] p;
        p = {1'b0, timing.short_low} + {1'b0, timing.read_sample};
        if (p > {1'b0, slot_len()})
            p = {1'b0, slot_len()};
        if (p == '0)
            p = (US_W+1)'(1);
        return p[US_W-1:0];
    endfunction

    // One timing step: update the sequencer and return the bus status after it
    function automatic t_result advance_bus(input logic tick, input logic level,
                                            input logic start, input t_func func,
                                            input logic [BYTE_W-1:0] tx);
        t_result        r;
        logic [US_W-1:0] slot_end;
        r = '0;
        if (bus_ph == PH_IDLE) begin
            if (start && func != FUNC_NONE) begin
                op_kind = func;
                tcount  = '0;
                bit_idx = '0;
                shreg   = tx;
                bus_ph  = (func == FUNC_RESET) ? PH_RST_LOW : PH_SLOT;
            end
        end else if (tick) begin
            tcount = tcount + 1'b1;
            case (bus_ph)
                PH_RST_LOW: begin
                    if (tcount >= timing.reset_low) begin
                        bus_ph = PH_RST_WAIT;
                        tcount = '0;
                    end
                end
                PH_RST_WAIT: begin
                    if (tcount >= timing.presence) begin
                        present = ~level;
                        bus_ph  = PH_IDLE;
                        tcount  = '0;
                        r.done  = 1'b1;
                    end
                end
                default: begin
                    slot_end = slot_len();
                    // sample comes before the end of slot in the same step
                    if (op_kind == FUNC_READ && tcount == sample_at())
                        shreg = {level, shreg[BYTE_W-1:1]};
                    if (tcount >= slot_end) begin
                        if (op_kind != FUNC_READ)
                            shreg = shreg >> 1;
                        tcount = '0;
                        if (bit_idx == 3'd7) begin
                            if (op_kind == FUNC_READ)
                                rd_byte = shreg;
                            bit_idx = '0;
                            bus_ph  = PH_IDLE;
                            r.done  = 1'b1;
                        end else begin
                            bit_idx = bit_idx + 1'b1;
                        end
                    end
                end
            endcase
        end
        r.drive_low = (bus_ph == PH_RST_LOW) ||
                      (bus_ph == PH_SLOT && tcount < pulse_len());
        r.busy      = (bus_ph != PH_IDLE);
        r.present   = present;
        r.rx_byte   = rd_byte;
        return r;
    endfunction

    // Register writes, prediction on each request, comparison on each result
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            timing.reset_low   = RST_RESET_LOW;
            timing.presence    = RST_PRESENCE;
            timing.short_low   = RST_SHORT_LOW;
            timing.long_low    = RST_LONG_LOW;
            timing.read_sample = RST_READ_SAMPLE;
            timing.slot        = RST_SLOT;
            bus_ph     = PH_IDLE;
            op_kind    = FUNC_RESET;
            tcount     = '0;
            bit_idx    = '0;
            shreg      = '0;
            rd_byte    = '0;
            present    = 1'b0;
            bus_status_q.delete();
            o_errors   = 0;
            o_checked  = 0;
            o_finished = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RESET_LOW:   timing.reset_low   = i_cfg_data;
                    REG_PRESENCE:    timing.presence    = i_cfg_data[US_W-1:0];
                    REG_SHORT_LOW:   timing.short_low   = i_cfg_data[US_W-1:0];
                    REG_LONG_LOW:    timing.long_low    = i_cfg_data[US_W-1:0];
                    REG_READ_SAMPLE: timing.read_sample = i_cfg_data[US_W-1:0];
                    REG_SLOT:        timing.slot        = i_cfg_data[US_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready)
                bus_status_q.push_back(advance_bus(i_tick, i_line_level, i_start_req,
                                                   t_func'(i_func), i_tx_byte));

            if (i_out_valid && i_out_ready) begin
                seen.drive_low = i_drive_low;
                seen.busy      = i_busy_res;
                seen.done      = i_done_res;
                seen.present   = i_device_present;
                seen.rx_byte   = i_rx_byte;
                if (bus_status_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= MAX_REPORTS)
                        $display("%0t: result with no request outstanding: drive %b busy %b",
                                 $time, seen.drive_low, seen.busy);
                end else begin
                    want = bus_status_q.pop_front();
                    if (want.done)
                        o_finished++;
                    if (seen !== want) begin
                        o_errors++;
                        if (o_errors <= MAX_REPORTS)
                            $display({"%0t: result %0d mismatch: expected drive %b busy %b ",
                                      "done %b present %b rx %h, got %b %b %b %b %h"},
                                     $time, o_checked, want.drive_low, want.busy, want.done,
                                     want.present, want.rx_byte, seen.drive_low, seen.busy,
                                     seen.done, seen.present, seen.rx_byte);
                    end
                    o_checked++;
                end
            end
        end
        o_pending = bus_status_q.size();
        o_busy    = (bus_ph != PH_IDLE);
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives timing steps and bus commands into the 1-Wire bus master under a
// range of timing settings and flow-control patterns; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb;
    import owb_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    // indexes past the last timing register, expected to be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic                  i_tick           = 1'b0;
    logic                  i_line_level     = 1'b1;
    logic                  i_start_req      = 1'b0;
    logic [1:0]            i_func           = FUNC_RESET;
    logic [BYTE_W-1:0]     i_tx_byte        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic                  o_drive_low;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic                  o_device_present;
    logic [BYTE_W-1:0]     o_rx_byte;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = REG_RESET_LOW;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    int   chk_errors;
    int   chk_pending;
    int   chk_checked;
    int   chk_finished;
    logic chk_busy;

    // Stimulus knobs
    int   send_gap_pct   = 0;
    int   take_stall_pct = 0;
    int   tick_pct       = 90;
    int   busy_start_pct = 20;
    bit   lvl_rand       = 1'b1;
    logic lvl_val        = 1'b1;
    bit   hold_off_req   = 1'b0;
    int   req_cnt        = 0;
    int   timing_sets    = 0;

    one_wire_bus_master u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_tick           (i_tick),
        .i_line_level     (i_line_level),
        .i_start_req      (i_start_req),
        .i_func           (i_func),
        .i_tx_byte        (i_tx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive_low      (o_drive_low),
        .o_busy_res       (o_busy_res),
        .o_done_res       (o_done_res),
        .o_device_present (o_device_present),
        .o_rx_byte        (o_rx_byte),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    owb_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_tick           (i_tick),
        .i_line_level     (i_line_level),
        .i_start_req      (i_start_req),
        .i_func           (i_func),
        .i_tx_byte        (i_tx_byte),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_drive_low      (o_drive_low),
        .i_busy_res       (o_busy_res),
        .i_done_res       (o_done_res),
        .i_device_present (o_device_present),
        .i_rx_byte        (o_rx_byte),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (chk_errors),
        .o_pending        (chk_pending),
        .o_checked        (chk_checked),
        .o_finished       (chk_finished),
        .o_busy           (chk_busy)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= take_stall_pct);
            end
        end
    end

    function automatic logic pick_level();
        return lvl_rand ? ($urandom_range(1) != 0) : lvl_val;
    endfunction

    // Offer one request and hold it until taken; entered and left at a falling edge
    task automatic put_req(input logic tick, input logic level, input logic start,
                           input logic [1:0] func, input logic [BYTE_W-1:0] tx);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_tick       <= tick;
        i_line_level <= level;
        i_start_req  <= start;
        i_func       <= func;
        i_tx_byte    <= tx;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        req_cnt++;
    endtask

    // Start a command, then keep the ticks coming until it has finished
    task automatic run_cmd(input t_func func, input logic [BYTE_W-1:0] tx);
        put_req($urandom_range(99) < tick_pct, pick_level(), 1'b1, func, tx);
        while (chk_busy)
            put_req($urandom_range(99) < tick_pct, pick_level(),
                    $urandom_range(99) < busy_start_pct, 2'($urandom_range(3)),
                    BYTE_W'($urandom));
    endtask

    task automatic run_random(input int n);
        int stop_at;
        int pick;
        stop_at = req_cnt + n;
        while (req_cnt < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 10)
                put_req($urandom_range(99) < tick_pct, pick_level(), 1'b0,
                        2'($urandom_range(3)), BYTE_W'($urandom));
            else if (pick < 15)
                run_cmd(FUNC_NONE, BYTE_W'($urandom));
            else if (pick < 40)
                run_cmd(FUNC_RESET, BYTE_W'($urandom));
            else if (pick < 70)
                run_cmd(FUNC_WRITE, BYTE_W'($urandom));
            else
                run_cmd(FUNC_READ, BYTE_W'($urandom));
        end
    endtask

    // Wait for every outstanding result, then let the inputs stay quiet to drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (chk_pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Narrow registers get junk in the unused top bits to check masking
    task automatic put_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        if (idx != REG_RESET_LOW)
            data[CFG_DATA_W-1:US_W] = (CFG_DATA_W-US_W)'($urandom_range(3));
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic load_timing(input logic [RST_W-1:0] rst_low, input logic [US_W-1:0] pres,
                               input logic [US_W-1:0] short_low, input logic [US_W-1:0] long_low,
                               input logic [US_W-1:0] rd_sample, input logic [US_W-1:0] slot);
        settle();
        put_cfg(REG_RESET_LOW, rst_low);
        put_cfg(REG_PRESENCE, CFG_DATA_W'(pres));
        put_cfg(REG_SHORT_LOW, CFG_DATA_W'(short_low));
        put_cfg(REG_LONG_LOW, CFG_DATA_W'(long_low));
        put_cfg(REG_READ_SAMPLE, CFG_DATA_W'(rd_sample));
        put_cfg(REG_SLOT, CFG_DATA_W'(slot));
        put_cfg(($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        timing_sets++;
    endtask

    // Random timing set with short phases
    task automatic load_random_timing();
        load_timing(RST_W'($urandom_range(12)), US_W'($urandom_range(8)),
                    US_W'($urandom_range(5)), US_W'($urandom_range(8)),
                    US_W'($urandom_range(6)), US_W'($urandom_range(9)));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Power-up timing, a tick on every step
        tick_pct = 100;
        run_cmd(FUNC_RESET, 8'h00);
        run_cmd(FUNC_WRITE, 8'hA5);

        // Directed: shortest legal timing, fixed line levels
        load_timing(10'd1, 8'd1, 8'd1, 8'd2, 8'd1, 8'd2);
        tick_pct       = 80;
        busy_start_pct = 50;
        put_req(1'b1, 1'b0, 1'b0, FUNC_READ, 8'hFF);   // no command
        put_req(1'b0, 1'b1, 1'b1, FUNC_NONE, 8'hFF);   // invalid command, ignored
        lvl_rand = 1'b0;
        lvl_val  = 1'b0;
        run_cmd(FUNC_RESET, 8'h00);                    // device answers
        lvl_val  = 1'b1;
        run_cmd(FUNC_RESET, 8'hFF);                    // empty bus
        run_cmd(FUNC_WRITE, 8'h00);
        run_cmd(FUNC_WRITE, 8'hFF);
        run_cmd(FUNC_READ, 8'h00);                     // reads all ones
        lvl_val  = 1'b0;
        run_cmd(FUNC_READ, 8'hFF);                     // reads all zeros
        lvl_rand = 1'b1;

        // Random commands over several timing sets and flow-control patterns
        tick_pct       = 85;
        busy_start_pct = 20;
        load_random_timing();
        run_random(100);

        load_random_timing();
        send_gap_pct = 65;
        run_random(100);

        // pulses longer than the slot, sample point past the slot end
        load_timing(10'd2, 8'd3, 8'd5, 8'd9, 8'd6, 8'd3);
        send_gap_pct   = 0;
        take_stall_pct = 65;
        run_random(100);

        // all timing registers zero
        load_timing('0, '0, '0, '0, '0, '0);
        send_gap_pct   = 28;
        take_stall_pct = 28;
        run_random(100);

        // long hold-off on results while requests keep coming
        load_random_timing();
        send_gap_pct   = 0;
        take_stall_pct = 0;
        hold_off_req   = 1'b1;
        run_random(100);

        load_timing(10'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2);
        take_stall_pct = 28;
        run_random(50);

        settle();
        $display("Run: %0d bus steps sent, %0d results checked, %0d commands finished, %s",
                 req_cnt, chk_checked, chk_finished, $sformatf("%0d timing sets.", timing_sets));
        $display("Timing went from power-up values and all-zero through stretched slots, %s",
                 "with request gaps, result stalls and a long result hold-off.");
        if (chk_errors == 0 && chk_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
